// ===== rtl/ajpt_pkg.sv =====
// shared types and constants of the angle jitter peak tracker
// depends on nothing; imported by the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package ajpt_pkg;

  localparam int unsigned WIN_W      = 5;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned ROOT_STEPS = 17;

  localparam logic [4:0]  WIN_RESET  = 5'd16;
  localparam logic [15:0] FOLD_LIMIT = 16'd11520;  // 180 degrees
  localparam logic [16:0] FULL_TURN  = 17'd23040;  // 360 degrees

  typedef enum logic [3:0] {
    S_IDLE,
    S_STORE,
    S_SETUP,
    S_WALK,
    S_DRAIN,
    S_FOLD,
    S_SQX,
    S_SQY,
    S_ROOT_INIT,
    S_ROOT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic store;
    logic setup;
    logic walk;
    logic fold;
    logic sq_x;
    logic sq_y;
    logic root_init;
    logic root_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic walk_last;
    logic root_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/ajpt_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ajpt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ajpt_ctrl.sv =====
// sequencing state machine of the angle jitter peak tracker
// depends on ajpt_pkg
`timescale 1ns / 1ps
`default_nettype none

module ajpt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ajpt_pkg::sts_t sts_i,
  output ajpt_pkg::cmd_t     cmd_o
);
  import ajpt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_STORE;
      S_STORE:     state_d = S_SETUP;
      S_SETUP:     state_d = sts_i.n_zero ? S_FOLD : S_WALK;
      S_WALK:      if (sts_i.walk_last) state_d = S_DRAIN;
      S_DRAIN:     state_d = S_FOLD;
      S_FOLD:      state_d = S_SQX;
      S_SQX:       state_d = S_SQY;
      S_SQY:       state_d = S_ROOT_INIT;
      S_ROOT_INIT: state_d = S_ROOT;
      S_ROOT:      if (sts_i.root_last) state_d = S_DONE;
      S_DONE:      if (sts_i.out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_STORE:     cmd_o.store = 1'b1;
      S_SETUP:     cmd_o.setup = 1'b1;
      S_WALK:      cmd_o.walk = 1'b1;
      S_DRAIN:     ;
      S_FOLD:      cmd_o.fold = 1'b1;
      S_SQX:       cmd_o.sq_x = 1'b1;
      S_SQY:       cmd_o.sq_y = 1'b1;
      S_ROOT_INIT: cmd_o.root_init = 1'b1;
      S_ROOT:      cmd_o.root_step = 1'b1;
      S_DONE:      cmd_o.load_out = sts_i.out_free;
      default:     ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ajpt_dp.sv =====
// datapath: ring bookkeeping, peak walk, squares, bit-serial square root, output register
// depends on ajpt_pkg and ajpt_ram
`timescale 1ns / 1ps
`default_nettype none

module ajpt_dp #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [4:0]         cfg_wdata_i,
  input  wire logic signed [15:0] pitch_in_i,
  input  wire logic signed [15:0] yaw_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [15:0]             deviation_o,
  output logic                    sample_taken_o,
  output logic                    has_data_o,
  input  wire ajpt_pkg::cmd_t     cmd_i,
  output ajpt_pkg::sts_t          sts_o
);
  import ajpt_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned MW = (CW > WIN_W) ? CW : WIN_W;
  localparam logic [CW-1:0] FULL = CW'(RING_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);
  localparam logic [4:0]    ROOT_LAST = 5'(ROOT_STEPS - 1);

  // captured transaction
  logic signed [15:0] pitch_q, yaw_q;
  logic               taken_q;
  // config and ring bookkeeping
  logic [4:0]    win_q;
  logic [AW-1:0] wp_q;
  logic [CW-1:0] fill_q;
  logic          seen_q;
  // walk
  logic [CW-1:0] n_q, k_q;
  logic [AW-1:0] rd_ptr_q;
  logic          rd_pend_q, rd_live_q, have_prev_q;
  logic [15:0]   prev_p_q, prev_y_q;
  logic [15:0]   hx_q, hy_q;
  // squares and root
  logic [32:0] sum_q;
  logic [33:0] rad_q;
  logic [20:0] rem_q;
  logic [16:0] root_q;
  logic [4:0]  rcnt_q;
  // output register
  logic        out_valid_q;
  logic [15:0] dev_q;
  logic        taken_out_q, has_q;

  logic [31:0] rdata;
  logic [MW-1:0] win_ext, fill_ext, n_min;
  logic [CW-1:0] n_comb;
  logic [15:0]   s_p, s_y, dp_abs, dy_abs;
  logic [16:0]   dp17, dy17, fold17, fold_abs;
  logic [15:0]   mul_a;
  logic [31:0]   prod;
  logic [20:0]   rem_sh, trial;

  ajpt_ram #(
    .WIDTH(32),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store && taken_q),
    .waddr_i(wp_q),
    .wdata_i({pitch_q, yaw_q}),
    .re_i   (cmd_i.walk),
    .raddr_i(rd_ptr_q),
    .rdata_o(rdata)
  );

  assign win_ext  = MW'(win_q);
  assign fill_ext = MW'(fill_q);
  assign n_min    = (win_ext < fill_ext) ? win_ext : fill_ext;
  assign n_comb   = n_min[CW-1:0];

  // slots never written read as zero
  assign s_p  = rd_live_q ? rdata[31:16] : 16'd0;
  assign s_y  = rd_live_q ? rdata[15:0] : 16'd0;
  assign dp17 = {s_p[15], s_p} - {prev_p_q[15], prev_p_q};
  assign dy17 = {s_y[15], s_y} - {prev_y_q[15], prev_y_q};
  assign dp_abs = dp17[16] ? 16'(-dp17) : dp17[15:0];
  assign dy_abs = dy17[16] ? 16'(-dy17) : dy17[15:0];

  assign fold17   = FULL_TURN - {1'b0, hy_q};
  assign fold_abs = fold17[16] ? (-fold17) : fold17;

  assign mul_a = cmd_i.sq_y ? hy_q : hx_q;
  assign prod  = mul_a * mul_a;

  assign rem_sh = {rem_q[18:0], rad_q[33:32]};
  assign trial  = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WIN_RESET;
      wp_q        <= '0;
      fill_q      <= '0;
      seen_q      <= 1'b0;
      rd_pend_q   <= 1'b0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      if (cmd_i.store && taken_q) begin
        wp_q   <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
        seen_q <= 1'b1;
        if (fill_q != FULL) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      rd_pend_q <= cmd_i.walk;
      if (cmd_i.setup) begin
        have_prev_q <= 1'b0;
      end else if (rd_pend_q) begin
        have_prev_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pitch_q <= pitch_in_i;
      yaw_q   <= yaw_in_i;
      taken_q <= (pitch_in_i != 16'sd0) || (yaw_in_i != 16'sd0);
    end
    if (cmd_i.setup) begin
      n_q      <= n_comb;
      k_q      <= '0;
      rd_ptr_q <= (wp_q == '0) ? LAST : wp_q - 1'b1;
      hx_q     <= '0;
      hy_q     <= '0;
    end
    if (cmd_i.walk) begin
      k_q       <= k_q + 1'b1;
      rd_ptr_q  <= (rd_ptr_q == '0) ? LAST : rd_ptr_q - 1'b1;
      rd_live_q <= CW'(rd_ptr_q) < fill_q;
    end
    if (rd_pend_q) begin
      prev_p_q <= s_p;
      prev_y_q <= s_y;
      if (have_prev_q) begin
        if (dp_abs > hx_q) hx_q <= dp_abs;
        if (dy_abs > hy_q) hy_q <= dy_abs;
      end
    end
    if (cmd_i.fold && (hy_q > FOLD_LIMIT)) begin
      hy_q <= fold_abs[15:0];
    end
    if (cmd_i.sq_x) begin
      sum_q <= {1'b0, prod};
    end
    if (cmd_i.sq_y) begin
      sum_q <= sum_q + {1'b0, prod};
    end
    if (cmd_i.root_init) begin
      rad_q  <= {1'b0, sum_q};
      rem_q  <= '0;
      root_q <= '0;
      rcnt_q <= '0;
    end
    if (cmd_i.root_step) begin
      rad_q  <= {rad_q[31:0], 2'b00};
      rcnt_q <= rcnt_q + 1'b1;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[15:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[15:0], 1'b0};
      end
    end
    if (cmd_i.load_out) begin
      dev_q       <= root_q[16] ? 16'hFFFF : root_q[15:0];
      taken_out_q <= taken_q;
      has_q       <= seen_q;
    end
  end

  assign sts_o.n_zero    = (n_comb == '0);
  assign sts_o.walk_last = (k_q == n_q);
  assign sts_o.root_last = (rcnt_q == ROOT_LAST);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign deviation_o    = dev_q;
  assign sample_taken_o = taken_out_q;
  assign has_data_o     = has_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL) else $error("fill count above ring depth");

  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= LAST) else $error("write pointer outside ring");

  a_seen_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.store && taken_q) |=> seen_q) else $error("stored sample did not set seen flag");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && !seen_q) |-> (sum_q == '0))
    else $error("nonzero deviation with empty ring");

endmodule

`default_nettype wire

// ===== rtl/angle_jitter_peak_tracker.sv =====
// top level of the angle jitter peak tracker
// depends on ajpt_pkg, ajpt_ctrl, ajpt_dp (which holds ajpt_ram)
`timescale 1ns / 1ps
`default_nettype none

// Tracks the peak pitch/yaw jitter of a stream of angle samples (1/64 degree units).
// Every input transaction gives exactly one result transaction. A sample with pitch
// and yaw both zero is not stored; any other sample goes into a ring of RING_DEPTH
// entries. The block then walks back over n = min(window_steps, stored count) neighbor
// pairs from the newest entry, keeps the largest absolute pitch and yaw steps, folds
// a yaw peak above 180 degrees to 360 minus the peak, and reports the floor square
// root of the sum of squares, saturated to 16 bits. One transaction is worked on at a
// time. The work time is set by the ring walk, skipped when no pair is examined, which
// does one ram read per cycle and then waits for the registered read data, and by the
// square root, which takes one result bit per cycle. The finished result sits in an
// output register, so the next transaction is accepted while it waits to be taken.
// window_steps is written through cfg_we_i / cfg_wdata_i, resets to 16, and must only
// be written while the block is idle. No clearing pass is needed after reset.

module angle_jitter_peak_tracker #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [4:0]         cfg_wdata_i,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] pitch_in_i,
  input  wire logic signed [15:0] yaw_in_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [15:0]             deviation_o,
  output logic                    sample_taken_o,
  output logic                    has_data_o
);
  import ajpt_pkg::*;

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // state machine: capture, store, walk, fold, square, root, deliver
  ajpt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // ring memory, peak registers, shared multiplier, root unit, output register
  ajpt_dp #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pitch_in_i    (pitch_in_i),
    .yaw_in_i      (yaw_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .deviation_o   (deviation_o),
    .sample_taken_o(sample_taken_o),
    .has_data_o    (has_data_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

`default_nettype wire
